>>> src/tomss_pkg.sv
// shared constants, command codes and item structs for the tile owner map block
package tomss_pkg;

  localparam int SCREEN_W_DEF = 1024;
  localparam int SCREEN_H_DEF = 512;

  // position arithmetic width, covers screen sizes up to 4096 and layer sums
  localparam int POS_W = 13;
  // tile coordinate width
  localparam int TILE_W = POS_W - 3;
  localparam int Z_W = 4;
  localparam int MAX_SPANS = 64;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_PAINT = 2'd1;
  localparam logic [1:0] CMD_SCAN  = 2'd2;

  typedef struct packed {
    logic [1:0]     cmd;
    logic [9:0]     layer_x;
    logic [9:0]     layer_y;
    logic [10:0]    layer_w;
    logic [10:0]    layer_h;
    logic [Z_W-1:0] layer_z;
    logic           visible;
    logic           direct;
    logic [10:0]    rect_x0;
    logic [10:0]    rect_x1;
    logic [9:0]     line;
  } item_t;

  typedef struct packed {
    logic        push;
    logic        span_valid;
    logic [9:0]  screen_x;
    logic [9:0]  screen_y;
    logic [9:0]  local_x;
    logic [10:0] span_width;
    logic        last;
  } res_t;

endpackage

>>> src/tile_owner_map_span_scan.sv
// top level: tile owner map with paint, clear and scanline span scan
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall   | cmd, layer geometry, z, flags, rect, line
//  out_    | output    | out_valid / out_stall | span_valid, screen/local x, y, width, last
//
// after reset the map is swept to zero, one tile a cycle, with in_stall high
// clear sweeps the map to zero the same way, then returns a last result; paint writes one tile a cycle
// scan reads one tile a cycle from the map ram, unless a finished span is blocked by out_stall
// one item is handled at a time; the one-tile-a-cycle walk over the map sets the rate
// out_stall holds finished spans in the output register and pending span, pausing the scan
module tile_owner_map_span_scan #(
  parameter int SCREEN_WIDTH  = tomss_pkg::SCREEN_W_DEF,
  parameter int SCREEN_HEIGHT = tomss_pkg::SCREEN_H_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [9:0]  in_layer_x,
  input  logic [9:0]  in_layer_y,
  input  logic [10:0] in_layer_w,
  input  logic [10:0] in_layer_h,
  input  logic [3:0]  in_layer_z,
  input  logic        in_visible,
  input  logic        in_direct,
  input  logic [10:0] in_rect_x0,
  input  logic [10:0] in_rect_x1,
  input  logic [9:0]  in_line,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_span_valid,
  output logic [9:0]  out_screen_x,
  output logic [9:0]  out_screen_y,
  output logic [9:0]  out_local_x,
  output logic [10:0] out_span_width,
  output logic        out_last
);
  import tomss_pkg::*;

  localparam int MAP_DEPTH = (SCREEN_WIDTH >> 3) * (SCREEN_HEIGHT >> 3);
  localparam int AW = $clog2(MAP_DEPTH);

  item_t          item;
  res_t           res;
  logic           out_free;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [Z_W-1:0] mem_wdata, mem_rdata;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic        out_span_valid_r;
  logic [9:0]  out_screen_x_r, out_screen_y_r, out_local_x_r;
  logic [10:0] out_span_width_r;
  logic        out_last_r;

  // pack the input fields for the sequencer
  assign item = '{cmd: in_cmd, layer_x: in_layer_x, layer_y: in_layer_y,
                  layer_w: in_layer_w, layer_h: in_layer_h, layer_z: in_layer_z,
                  visible: in_visible, direct: in_direct, rect_x0: in_rect_x0,
                  rect_x1: in_rect_x1, line: in_line};

  // the output register can take a new result when empty or being drained
  assign out_free = !out_valid_r || !out_stall;

  tomss_ctrl #(
    .SCREEN_WIDTH (SCREEN_WIDTH),
    .SCREEN_HEIGHT(SCREEN_HEIGHT)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (item),
    .out_free (out_free),
    .res      (res),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_re   (mem_re),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  // one 4-bit owner z per 8x8 tile, row-major
  tomss_map_ram #(
    .DEPTH(MAP_DEPTH)
  ) u_map (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .re   (mem_re),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  always_comb begin
    if (res.push) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload only loads on a push, so a stalled result holds
  always_ff @(posedge clk) begin
    if (res.push) begin
      out_span_valid_r <= res.span_valid;
      out_screen_x_r   <= res.screen_x;
      out_screen_y_r   <= res.screen_y;
      out_local_x_r    <= res.local_x;
      out_span_width_r <= res.span_width;
      out_last_r       <= res.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_span_valid = out_span_valid_r;
  assign out_screen_x   = out_screen_x_r;
  assign out_screen_y   = out_screen_y_r;
  assign out_local_x    = out_local_x_r;
  assign out_span_width = out_span_width_r;
  assign out_last       = out_last_r;

endmodule

>>> src/tomss_map_ram.sv
// tile owner map storage, one write port and one registered read port
module tomss_map_ram #(
  parameter int DEPTH = 8192,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [tomss_pkg::Z_W-1:0] wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output logic [tomss_pkg::Z_W-1:0] rdata
);
  import tomss_pkg::*;

  logic [Z_W-1:0] mem [DEPTH];
  logic [Z_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/tomss_ctrl.sv
// command sequencer: map clear sweep, paint walk and scanline run merging
module tomss_ctrl #(
  parameter int SCREEN_WIDTH  = tomss_pkg::SCREEN_W_DEF,
  parameter int SCREEN_HEIGHT = tomss_pkg::SCREEN_H_DEF,
  localparam int MAP_DEPTH = (SCREEN_WIDTH >> 3) * (SCREEN_HEIGHT >> 3),
  localparam int AW = $clog2(MAP_DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  tomss_pkg::item_t         in_item,
  input  logic                     out_free,
  output tomss_pkg::res_t          res,
  output logic                     mem_we,
  output logic [AW-1:0]            mem_waddr,
  output logic [tomss_pkg::Z_W-1:0] mem_wdata,
  output logic                     mem_re,
  output logic [AW-1:0]            mem_raddr,
  input  logic [tomss_pkg::Z_W-1:0] mem_rdata
);
  import tomss_pkg::*;

  localparam int MAP_COLS = SCREEN_WIDTH >> 3;
  localparam int MAP_ROWS = SCREEN_HEIGHT >> 3;
  localparam int SW = ((AW > POS_W) ? AW : POS_W) + 1;
  localparam int CNT_W = $clog2(MAX_SPANS + 1);

  localparam logic [2:0] ST_CLR   = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_PAINT = 3'd3;
  localparam logic [2:0] ST_SCAN  = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;

  // control state
  logic [2:0]       state_r, state_nxt;
  logic [AW-1:0]    clr_addr_r, clr_addr_nxt;
  logic             clr_reply_r, clr_reply_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic             in_run_r, in_run_nxt;
  logic             ev_valid_r, ev_valid_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  // payload state
  item_t             it_r, it_nxt;
  logic [AW-1:0]     base_r, base_nxt;
  logic [POS_W-1:0]  x1c_r, x1c_nxt;
  logic [POS_W-1:0]  a1_r, a1_nxt;
  logic [POS_W-1:0]  vy_r, vy_nxt;
  logic [POS_W-1:0]  dx_r, dx_nxt;
  logic [POS_W-1:0]  vx_r, vx_nxt;
  logic [POS_W-1:0]  ev_dx_r, ev_dx_nxt;
  logic [POS_W-1:0]  run_start_r, run_start_nxt;
  logic [POS_W-1:0]  run_end_r, run_end_nxt;
  logic [TILE_W-1:0] row_r, row_nxt;
  logic [TILE_W-1:0] col_r, col_nxt;
  logic [TILE_W-1:0] col_start_r, col_start_nxt;
  logic [TILE_W-1:0] col_end_r, col_end_nxt;
  logic [TILE_W-1:0] row_end_r, row_end_nxt;
  logic [9:0]        pend_sx_r, pend_sx_nxt;
  logic [9:0]        pend_lx_r, pend_lx_nxt;
  logic [10:0]       pend_w_r, pend_w_nxt;

  // setup decode
  logic [POS_W-1:0]  lx, ly, x0, w, h, x1c, vy, x1c_p7, w_p7, h_p7;
  logic [TILE_W-1:0] sx, sy, bw, bh, sx_bw, sy_bh, col_end, row_end;
  logic              scan_ok, paint_ok;

  // scan step
  logic             issue_ok, hit, scan_done, close_run, make_span, blocked, push_mid;
  logic [POS_W-1:0] sa, se, span_sx, span_w;
  logic [SW-1:0]    rd_sum, wr_sum;

  always_comb begin
    lx     = POS_W'({it_r.layer_x[9:3], 3'b000});
    ly     = POS_W'({it_r.layer_y[9:3], 3'b000});
    x0     = POS_W'(it_r.rect_x0);
    w      = POS_W'(it_r.layer_w);
    h      = POS_W'(it_r.layer_h);
    x1c    = (POS_W'(it_r.rect_x1) > w) ? w : POS_W'(it_r.rect_x1);
    vy     = ly + POS_W'(it_r.line);
    x1c_p7 = x1c + POS_W'(7);
    w_p7   = w + POS_W'(7);
    h_p7   = h + POS_W'(7);
    sx     = TILE_W'(it_r.layer_x[9:3]);
    sy     = TILE_W'(it_r.layer_y[9:3]);
    bw     = w_p7[POS_W-1:3];
    bh     = h_p7[POS_W-1:3];
    sx_bw  = sx + bw;
    sy_bh  = sy + bh;
    col_end = (sx_bw > TILE_W'(MAP_COLS)) ? TILE_W'(MAP_COLS) : sx_bw;
    row_end = (sy_bh > TILE_W'(MAP_ROWS)) ? TILE_W'(MAP_ROWS) : sy_bh;
    scan_ok = (it_r.cmd == CMD_SCAN) && it_r.visible && !it_r.direct &&
              (POS_W'(it_r.line) < h) && (x0 < x1c) && (vy < POS_W'(SCREEN_HEIGHT));
    paint_ok = (it_r.cmd == CMD_PAINT) && it_r.visible && (sx < col_end) &&
               (sy < row_end);
  end

  always_comb begin
    issue_ok  = (dx_r < a1_r) && (vx_r < POS_W'(SCREEN_WIDTH));
    hit       = (mem_rdata == it_r.layer_z);
    scan_done = !ev_valid_r && !issue_ok;
    close_run = in_run_r && ((ev_valid_r && !hit) || scan_done);
    // clip the run to the region
    sa        = (run_start_r < x0) ? x0 : run_start_r;
    se        = (run_end_r > x1c_r) ? x1c_r : run_end_r;
    span_sx   = lx + sa;
    span_w    = se - sa;
    make_span = close_run && (se > sa);
    blocked   = make_span && pend_valid_r && !out_free;
    push_mid  = make_span && pend_valid_r && out_free;
    rd_sum    = SW'(base_r) + SW'(vx_r[POS_W-1:3]);
    wr_sum    = SW'(base_r) + SW'(col_r);
  end

  always_comb begin
    state_nxt      = state_r;
    clr_addr_nxt   = clr_addr_r;
    clr_reply_nxt  = clr_reply_r;
    pend_valid_nxt = pend_valid_r;
    in_run_nxt     = in_run_r;
    ev_valid_nxt   = ev_valid_r;
    cnt_nxt        = cnt_r;
    it_nxt         = it_r;
    base_nxt       = base_r;
    x1c_nxt        = x1c_r;
    a1_nxt         = a1_r;
    vy_nxt         = vy_r;
    dx_nxt         = dx_r;
    vx_nxt         = vx_r;
    ev_dx_nxt      = ev_dx_r;
    run_start_nxt  = run_start_r;
    run_end_nxt    = run_end_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    col_start_nxt  = col_start_r;
    col_end_nxt    = col_end_r;
    row_end_nxt    = row_end_r;
    pend_sx_nxt    = pend_sx_r;
    pend_lx_nxt    = pend_lx_r;
    pend_w_nxt     = pend_w_r;
    in_stall       = 1'b1;
    mem_we         = 1'b0;
    mem_waddr      = clr_addr_r;
    mem_wdata      = '0;
    mem_re         = 1'b0;
    mem_raddr      = rd_sum[AW-1:0];
    res            = '0;

    unique case (state_r)
      ST_CLR: begin
        mem_we       = 1'b1;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(MAP_DEPTH - 1)) begin
          state_nxt = clr_reply_r ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          it_nxt = in_item;
          if (in_item.cmd == CMD_CLEAR) begin
            state_nxt     = ST_CLR;
            clr_addr_nxt  = '0;
            clr_reply_nxt = 1'b1;
          end else begin
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        x1c_nxt = x1c;
        a1_nxt  = {x1c_p7[POS_W-1:3], 3'b000};
        vy_nxt  = vy;
        if (scan_ok) begin
          state_nxt    = ST_SCAN;
          base_nxt     = AW'(MAP_COLS * int'(vy[POS_W-1:3]));
          dx_nxt       = {x0[POS_W-1:3], 3'b000};
          vx_nxt       = lx + {x0[POS_W-1:3], 3'b000};
          in_run_nxt   = 1'b0;
          ev_valid_nxt = 1'b0;
          cnt_nxt      = '0;
        end else if (paint_ok) begin
          state_nxt     = ST_PAINT;
          base_nxt      = AW'(MAP_COLS * int'(sy));
          row_nxt       = sy;
          col_nxt       = sx;
          col_start_nxt = sx;
          col_end_nxt   = col_end;
          row_end_nxt   = row_end;
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_PAINT: begin
        mem_we    = 1'b1;
        mem_waddr = wr_sum[AW-1:0];
        mem_wdata = it_r.layer_z;
        if (col_r + TILE_W'(1) == col_end_r) begin
          col_nxt  = col_start_r;
          row_nxt  = row_r + TILE_W'(1);
          base_nxt = base_r + AW'(MAP_COLS);
          if (row_r + TILE_W'(1) == row_end_r) begin
            state_nxt = ST_FLUSH;
          end
        end else begin
          col_nxt = col_r + TILE_W'(1);
        end
      end
      ST_SCAN: begin
        res.push       = push_mid;
        res.span_valid = 1'b1;
        res.screen_x   = pend_sx_r;
        res.screen_y   = vy_r[9:0];
        res.local_x    = pend_lx_r;
        res.span_width = pend_w_r;
        res.last       = 1'b0;
        if (!blocked) begin
          // read of the next tile overlaps evaluation of the previous one
          mem_re       = issue_ok;
          ev_valid_nxt = issue_ok;
          ev_dx_nxt    = dx_r;
          if (issue_ok) begin
            dx_nxt = dx_r + POS_W'(8);
            vx_nxt = vx_r + POS_W'(8);
          end
          if (ev_valid_r && hit) begin
            in_run_nxt  = 1'b1;
            run_end_nxt = ev_dx_r + POS_W'(8);
            if (!in_run_r) begin
              run_start_nxt = ev_dx_r;
            end
          end else if (close_run) begin
            in_run_nxt = 1'b0;
          end
          if (make_span) begin
            pend_valid_nxt = 1'b1;
            pend_sx_nxt    = span_sx[9:0];
            pend_lx_nxt    = sa[9:0];
            pend_w_nxt     = span_w[10:0];
            cnt_nxt        = cnt_r + CNT_W'(1);
          end
          if (scan_done || (make_span && (cnt_r + CNT_W'(1) == CNT_W'(MAX_SPANS)))) begin
            state_nxt = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        ev_valid_nxt   = 1'b0;
        res.push       = out_free;
        res.span_valid = pend_valid_r;
        res.screen_x   = pend_valid_r ? pend_sx_r : '0;
        res.screen_y   = pend_valid_r ? vy_r[9:0] : '0;
        res.local_x    = pend_valid_r ? pend_lx_r : '0;
        res.span_width = pend_valid_r ? pend_w_r : '0;
        res.last       = 1'b1;
        if (out_free) begin
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLR;
      clr_addr_r   <= '0;
      clr_reply_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      in_run_r     <= 1'b0;
      ev_valid_r   <= 1'b0;
      cnt_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      clr_reply_r  <= clr_reply_nxt;
      pend_valid_r <= pend_valid_nxt;
      in_run_r     <= in_run_nxt;
      ev_valid_r   <= ev_valid_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    it_r        <= it_nxt;
    base_r      <= base_nxt;
    x1c_r       <= x1c_nxt;
    a1_r        <= a1_nxt;
    vy_r        <= vy_nxt;
    dx_r        <= dx_nxt;
    vx_r        <= vx_nxt;
    ev_dx_r     <= ev_dx_nxt;
    run_start_r <= run_start_nxt;
    run_end_r   <= run_end_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    col_start_r <= col_start_nxt;
    col_end_r   <= col_end_nxt;
    row_end_r   <= row_end_nxt;
    pend_sx_r   <= pend_sx_nxt;
    pend_lx_r   <= pend_lx_nxt;
    pend_w_r    <= pend_w_nxt;
  end

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    res.push |-> out_free)
    else $error("result pushed into a full output register");

  a_span_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_SPANS))
    else $error("span count above limit");

  a_write_owner: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_CLR || state_r == ST_PAINT))
    else $error("map written outside clear or paint");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    (res.push && res.last) |=> (state_r == ST_IDLE && !pend_valid_r))
    else $error("item not finished after its last result");

endmodule
